// ===== design/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared constants, types and helpers for the signed truncating divider.
// ----------------------------------------------------------------------------
package sdt_pkg;

	localparam int Width = 32;
	localparam int CntW  = $clog2(Width);

	// most positive value, used for saturation
	localparam logic [Width-1:0] MaxPos = {1'b0, {(Width-1){1'b1}}};

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SETUP = 4'b0010,
		S_RUN   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture operands
		logic setup;   // take magnitudes, clear remainder
		logic step;    // one restoring iteration
		logic finish;  // sign fix-up into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register empty or being drained
	} sts_t;

	// magnitude of a two's complement word
	function automatic logic [Width-1:0] mag_f(input logic [Width-1:0] v);
		logic [Width-1:0] r;
		r = v[Width-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

// ===== design/sdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdt_ctrl
// Sequencer for the divider: setup, one iteration per quotient bit, fix-up.
// ----------------------------------------------------------------------------
module sdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  sdt_pkg::sts_t   sts,
	output sdt_pkg::cmd_t   cmd
);

	sdt_pkg::state_t               state_q;
	sdt_pkg::state_t               state_nx;
	logic [sdt_pkg::CntW-1:0]      cnt_q;

	assign s_tready   = (state_q == sdt_pkg::S_IDLE);
	assign cmd.load   = s_tready && s_tvalid;
	assign cmd.setup  = (state_q == sdt_pkg::S_SETUP);
	assign cmd.step   = (state_q == sdt_pkg::S_RUN);
	assign cmd.finish = (state_q == sdt_pkg::S_DONE) && sts.out_free;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sdt_pkg::S_IDLE:  if (s_tvalid) state_nx = sdt_pkg::S_SETUP;
			sdt_pkg::S_SETUP: state_nx = sdt_pkg::S_RUN;
			sdt_pkg::S_RUN:   if (cnt_q == '0) state_nx = sdt_pkg::S_DONE;
			sdt_pkg::S_DONE:  if (sts.out_free) state_nx = sdt_pkg::S_IDLE;
			default:          state_nx = sdt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdt_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.setup) begin
				cnt_q <= sdt_pkg::CntW'(sdt_pkg::Width - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/sdt_dp.sv =====
// ----------------------------------------------------------------------------
// sdt_dp
// Divider datapath: operand capture, restoring magnitude divide, sign
// fix-up and the output register.
// ----------------------------------------------------------------------------
module sdt_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2*sdt_pkg::Width-1:0] s_tdata,
	input  sdt_pkg::cmd_t             cmd,
	output sdt_pkg::sts_t             sts,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [sdt_pkg::Width-1:0] m_tdata,
	output logic [1:0]                m_tuser
);

	localparam int W = sdt_pkg::Width;

	logic [W-1:0] num_q;
	logic [W-1:0] den_q;
	logic [W-1:0] mb_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic         neg_q;
	logic         vld_q;
	logic [W:0]   trial;
	logic [W-1:0] q_fix;
	logic         ovf;
	logic         dz;

	assign sts.out_free = !vld_q || m_tready;
	assign m_tvalid     = vld_q;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, mb_q};

	// dividend bits are shifted out of quo_q while quotient bits shift in
	always_comb begin
		dz    = (mb_q == '0);
		ovf   = !dz && !neg_q && quo_q[W-1];
		q_fix = quo_q;
		priority if (dz) begin
			q_fix = '0;
		end else if (neg_q) begin
			q_fix = ~quo_q + 1'b1;
		end else if (ovf) begin
			q_fix = sdt_pkg::MaxPos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= s_tdata[W-1:0];
			den_q <= s_tdata[2*W-1:W];
		end
		if (cmd.setup) begin
			quo_q <= sdt_pkg::mag_f(num_q);
			mb_q  <= sdt_pkg::mag_f(den_q);
			neg_q <= num_q[W-1] ^ den_q[W-1];
			rem_q <= '0;
		end else if (cmd.step) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			m_tdata <= q_fix;
			m_tuser <= {dz, ovf};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.finish) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

endmodule

// ===== design/signed_divide_truncate_top.sv =====
// ----------------------------------------------------------------------------
// signed_divide_truncate_top
// Signed 32-bit divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// Each word, once accepted, forms its operand magnitudes, then runs 32 restoring
// iterations of the single subtractor (one quotient bit each), then does the
// sign fix-up into the output register. A new word is accepted on the cycle
// after the fix-up, even if the previous result has not been taken yet; no new
// word is accepted while one is in progress. The fix-up waits while an older
// result still sits untaken in the output register. Most negative over minus
// one saturates to the largest positive value with overflow set; a zero
// divisor gives quotient 0 with div_by_zero set.
module signed_divide_truncate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] numerator, [63:32] denominator
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] quotient
	output logic [1:0]  m_tuser    // [0] overflow, [1] div_by_zero
);

	sdt_pkg::cmd_t cmd;
	sdt_pkg::sts_t sts;

	sdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed truncating divider: directed corner
// words, then randomized operands under three sender/receiver idle mixes,
// with a long receiver hold-off to back up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	localparam int Width = sdt_pkg::Width;

	localparam logic [Width-1:0] MostNeg = {1'b1, {(Width-1){1'b0}}};
	localparam logic [Width-1:0] MostPos = {1'b0, {(Width-1){1'b1}}};
	localparam logic [Width-1:0] MinusOne = '1;
	localparam int RandPerPhase = 610;

	typedef struct packed {
		logic [Width-1:0] quotient;
		logic             overflow;
		logic             div_by_zero;
	} quot_t;

	// expected quotients, oldest first
	class quot_board;
		quot_t pending_quots[$];
		int    mismatches = 0;

		task report(string what);
			mismatches++;
			if (mismatches <= 30)
				$display("%0t MISMATCH: %s", $realtime, what);
		endtask

		function quot_t divide_trunc(logic [Width-1:0] num, logic [Width-1:0] den);
			logic             num_neg, den_neg;
			logic [Width-1:0] num_mag, den_mag, mag_q;
			quot_t            r;
			num_neg = num[Width-1];
			den_neg = den[Width-1];
			num_mag = num_neg ? -num : num;
			den_mag = den_neg ? -den : den;
			r = '0;
			if (den_mag == '0) begin
				r.div_by_zero = 1'b1;
			end else begin
				mag_q = num_mag / den_mag;
				if (num_neg != den_neg) begin
					r.quotient = -mag_q;
				end else if (mag_q > MostPos) begin
					// most negative over minus one
					r.quotient = MostPos;
					r.overflow = 1'b1;
				end else begin
					r.quotient = mag_q;
				end
			end
			return r;
		endfunction

		function void note_operands(logic [Width-1:0] num, logic [Width-1:0] den);
			pending_quots.insert(pending_quots.size(), divide_trunc(num, den));
		endfunction

		task check_result(logic [Width-1:0] quotient, logic [1:0] flags);
			quot_t want;
			if (pending_quots.size() == 0) begin
				report($sformatf("unexpected word q=%h flags=%b", quotient, flags));
			end else begin
				want = pending_quots.pop_front();
				if (quotient !== want.quotient)
					report($sformatf("quotient %h, want %h", quotient, want.quotient));
				if (flags[0] !== want.overflow)
					report($sformatf("overflow %b, want %b (q %h)", flags[0], want.overflow,
						want.quotient));
				if (flags[1] !== want.div_by_zero)
					report($sformatf("div_by_zero %b, want %b (q %h)", flags[1],
						want.div_by_zero, want.quotient));
			end
		endtask

		function int pending();
			return pending_quots.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	quot_board sb = new;
	int        snd_idle = 15;
	int        rcv_idle = 47;
	int        hold_left = 0;

	signed_divide_truncate_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offer one word, hold it until taken, then maybe go idle a while
	task send_word(logic [Width-1:0] num, logic [Width-1:0] den);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {den, num};
		do @(posedge clk); while (!s_tready);
		sb.note_operands(num, den);
		gap = 0;
		while ($urandom_range(99) < snd_idle)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function bit case_neg();
		return $urandom_range(1);
	endfunction

	function logic [Width-1:0] rand_operand(bit divisor);
		logic [Width-1:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = $urandom;
			3:       v = $urandom_range(255);
			4, 5:    v = $urandom >> $urandom_range(Width - 1);
			6:       v = $urandom_range(3) == 0 ? MostNeg : MostPos;
			7:       v = MostNeg + $urandom_range(4);
			8:       v = divisor ? MinusOne : MostPos - $urandom_range(4);
			default: v = divisor && $urandom_range(1) ? '0 : $urandom_range(2);
		endcase
		if (case_neg())
			v = -v;
		return v;
	endfunction

	// receiver: takes words, stalls at random or for a counted hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [Width-1:0] num, den;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: saturation, zero divisor, sign combos, extremes
		send_word(MostNeg, MinusOne);
		send_word(MostNeg, 1);
		send_word(MostNeg, MostNeg);
		send_word(MostPos, MostNeg);
		send_word(0, 0);
		send_word(5, 0);
		send_word(MostNeg, 0);
		send_word(MinusOne, 0);
		send_word(MostPos, MinusOne);
		send_word(7, 2);
		send_word(-7, 2);
		send_word(7, -2);
		send_word(-7, -2);
		send_word(0, MinusOne);
		send_word(MostNeg, 2);
		send_word(MostNeg, -2);
		send_word(1, MostNeg);
		send_word(MinusOne, MostNeg);
		send_word(MostPos, MostPos);
		send_word(MostPos, 1);
		send_word(-1073741824, MinusOne);
		send_word(MostNeg, -1073741824);
		send_word(3, MostPos);
		send_word(MostPos, MostNeg + 1);
		drain();

		// back up the pipe: receiver holds off while words keep coming
		snd_idle  = 0;
		hold_left = 400;
		repeat (12)
			send_word($urandom, $urandom_range(1) ? $urandom : $urandom_range(9) + 1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			snd_idle = phase == 0 ? 15 : phase == 1 ? 47 : 0;
			rcv_idle = phase == 0 ? 47 : phase == 1 ? 15 : 0;
			for (int i = 0; i < RandPerPhase; i++) begin
				if ($urandom_range(49) == 0) begin
					num = MostNeg;
					den = MinusOne;
				end else begin
					num = rand_operand(1'b0);
					den = rand_operand(1'b1);
				end
				send_word(num, den);
			end
			// sender waits for every result before the next mix
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
